/* hdl/ctim_pkg.sv */
// ----------------------------------------------------------------------------
// Color to id map package
// Shared widths, codes and beat types for the color to indicator id map.
// ----------------------------------------------------------------------------
package ctim_pkg;

   // Number of pool slots, one cell per slot.
   localparam int POOL_DEPTH = 8;

   // Pointer and active count hold 0..POOL_DEPTH.
   localparam int PTR_W = $clog2(POOL_DEPTH + 1);

   // Fixed field widths.
   localparam int OP_W     = 2;
   localparam int COLOR_W  = 24;
   localparam int SLOT_W   = 3;
   localparam int ID_W     = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 4;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EVICT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE  = 3'd4;

   // Request beat.
   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [COLOR_W-1:0] color;
      logic [SLOT_W-1:0]  slot;
      logic [ID_W-1:0]    pool_id;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [ID_W-1:0]     indicator_id;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Data handed from one cell to its right neighbor.
   typedef struct packed {
      logic            hit_seen;
      logic [ID_W-1:0] hit_id;
      logic            free_seen;
      logic [ID_W-1:0] free_id;
      logic [ID_W-1:0] victim_id;
   } link_type;

   // Controls broadcast to every cell.
   typedef struct packed {
      logic               acquire;
      logic               any_hit;
      logic               any_free;
      logic               clear;
      logic [COLOR_W-1:0] color;
      logic [ID_W-1:0]    pool_id;
   } bcast_type;

   // Controls private to one cell.
   typedef struct packed {
      logic active;
      logic victim;
      logic load;
   } sel_type;

endpackage

/* hdl/color_to_id_map_round_robin.sv */
// ----------------------------------------------------------------------------
// Color to indicator id map with round-robin replacement
// Maps a 24-bit color to an id from a small pool held in a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (req_valid/req_stall/req_data) carry an opcode: acquire an
//   id for a color, load one slot's id, or clear every binding. Each request
//   produces exactly one response beat (rsp_valid/rsp_stall/rsp_data) with an
//   id and a status code.
//   csr_wr_en/csr_wr_data set the pool count; a write also unbinds all slots.
//   Write it only while no request is in flight.
//   The response is registered: rsp_valid rises in the cycle after request
//   acceptance. One beat is taken every cycle while req_stall is low: the slot
//   cells compare all slots at once and the hit, first free slot and victim
//   resolve along the cell chain in the same cycle, which sets the clock-to-clock path.
//   While the response register is full and stalled, req_stall is raised;
//   the response holds until taken.
//   Synchronous reset unbinds every slot, zeroes the pool count and the
//   round-robin pointer and empties the response register. Slot ids are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module color_to_id_map_round_robin (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ctim_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ctim_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [ctim_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int N = ctim_pkg::POOL_DEPTH;

   logic [ctim_pkg::COUNT_W-1:0] count_ff;
   logic [ctim_pkg::COUNT_W-1:0] count_in;
   logic [ctim_pkg::PTR_W-1:0]   ptr_ff;
   logic [ctim_pkg::PTR_W-1:0]   ptr_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ctim_pkg::rsp_type            rsp_data_ff;
   ctim_pkg::rsp_type            rsp_data_in;

   logic                         accept;
   logic                         is_acquire;
   logic                         pool_empty;
   logic [ctim_pkg::PTR_W-1:0]   n_eff;
   logic [ctim_pkg::PTR_W-1:0]   ptr_eff;
   logic                         evict;
   ctim_pkg::bcast_type          bcast;
   ctim_pkg::sel_type            sel [N];
   ctim_pkg::link_type           link [N+1];

   // Handshake: a new beat enters unless a finished response is stalled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Active slot count saturates at the pool depth.
   always_comb begin
      if (int'(count_ff) > N) begin
         n_eff = ctim_pkg::PTR_W'(N);
      end else begin
         n_eff = ctim_pkg::PTR_W'(count_ff);
      end
   end

   assign pool_empty = (n_eff == '0);
   assign is_acquire = accept && (req_data.opcode == ctim_pkg::OP_ACQUIRE);

   // Pointer restarts at slot zero when it is not below the active count.
   assign ptr_eff = (ptr_ff >= n_eff) ? '0 : ptr_ff;

   // Broadcast controls; hit and free summaries come from the chain's end.
   always_comb begin
      bcast.acquire  = is_acquire && !pool_empty;
      bcast.any_hit  = link[N].hit_seen;
      bcast.any_free = link[N].free_seen;
      bcast.clear    = csr_wr_en ||
                       (accept && (req_data.opcode == ctim_pkg::OP_CLEAR));
      bcast.color    = req_data.color;
      bcast.pool_id  = req_data.pool_id;
   end

   assign link[0] = '0;

   // Row of slot cells, each handing the lookup chain to its neighbor.
   for (genvar i = 0; i < N; i++) begin : g_cell
      always_comb begin
         sel[i].active = int'(n_eff) > i;
         sel[i].victim = int'(ptr_eff) == i;
         sel[i].load   = accept && (req_data.opcode == ctim_pkg::OP_LOAD) &&
                         (int'(req_data.slot) == i);
      end

      ctim_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bcast    (bcast),
         .sel      (sel[i]),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   // Eviction happens when an acquire misses and every active slot is bound.
   assign evict = bcast.acquire && !link[N].hit_seen && !link[N].free_seen;

   // Pool count and pointer next state.
   always_comb begin
      count_in = csr_wr_en ? csr_wr_data : count_ff;
      ptr_in   = evict ? (ptr_eff + ctim_pkg::PTR_W'(1)) : ptr_ff;
   end

   // Response beat contents.
   always_comb begin
      rsp_data_in.indicator_id = '0;
      rsp_data_in.status       = ctim_pkg::ST_DONE;
      if (is_acquire) begin
         if (link[N].hit_seen) begin
            rsp_data_in.indicator_id = link[N].hit_id;
            rsp_data_in.status       = ctim_pkg::ST_HIT;
         end else if (pool_empty) begin
            rsp_data_in.status       = ctim_pkg::ST_EMPTY;
         end else if (link[N].free_seen) begin
            rsp_data_in.indicator_id = link[N].free_id;
            rsp_data_in.status       = ctim_pkg::ST_FREE;
         end else begin
            rsp_data_in.indicator_id = link[N].victim_id;
            rsp_data_in.status       = ctim_pkg::ST_EVICT;
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register loads only with a new beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/ctim_cell.sv */
// ----------------------------------------------------------------------------
// Color to id map slot cell
// Holds one pool slot (id, binding, color) and extends the lookup chain.
// ----------------------------------------------------------------------------
module ctim_cell (
   input  logic                clock,
   input  logic                reset,
   input  ctim_pkg::bcast_type bcast,
   input  ctim_pkg::sel_type   sel,
   input  ctim_pkg::link_type  link_in,
   output ctim_pkg::link_type  link_out
);

   logic                         bound_ff;
   logic                         bound_in;
   logic [ctim_pkg::COLOR_W-1:0] color_ff;
   logic [ctim_pkg::COLOR_W-1:0] color_in;
   logic [ctim_pkg::ID_W-1:0]    id_ff;
   logic [ctim_pkg::ID_W-1:0]    id_in;
   logic                         my_hit;
   logic                         my_free;
   logic                         take_slot;

   // Local match and free detection for an active slot.
   assign my_hit  = sel.active && bound_ff && (color_ff == bcast.color);
   assign my_free = sel.active && !bound_ff;

   // The first hit and first free slot from the left win; the victim is one-hot.
   always_comb begin
      link_out.hit_seen  = link_in.hit_seen | my_hit;
      link_out.hit_id    = link_in.hit_seen ? link_in.hit_id : (my_hit ? id_ff : '0);
      link_out.free_seen = link_in.free_seen | my_free;
      link_out.free_id   = link_in.free_seen ? link_in.free_id : (my_free ? id_ff : '0);
      link_out.victim_id = sel.victim ? id_ff : link_in.victim_id;
   end

   // Bind on a miss: to the first free slot, or to the victim when all are bound.
   assign take_slot = bcast.acquire && !bcast.any_hit &&
                      ((my_free && !link_in.free_seen) ||
                       (!bcast.any_free && sel.active && sel.victim));

   // Next slot state.
   always_comb begin
      bound_in = bound_ff;
      color_in = color_ff;
      id_in    = id_ff;
      if (bcast.clear) begin
         bound_in = 1'b0;
      end else if (take_slot) begin
         bound_in = 1'b1;
         color_in = bcast.color;
      end
      if (sel.load) begin
         id_in = bcast.pool_id;
      end
   end

   // Binding flag is control state; color and id are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= 1'b0;
      end else begin
         bound_ff <= bound_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      id_ff    <= id_in;
   end

endmodule
